FILE: src/tbrf_pkg.sv
// Package for the transactional byte ring FIFO.
// Holds sizes, the command codes and the result beat type; no dependencies.
package tbrf_pkg;

  localparam int DEPTH = 256;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 9;
  localparam int DATA_W = 8;
  localparam int CMD_W = 3;

  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CAP_MIN = CNT_W'(1);

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR       = 3'd0,
    CMD_BEGIN_PUSH  = 3'd1,
    CMD_PUSH        = 3'd2,
    CMD_COMMIT_PUSH = 3'd3,
    CMD_BEGIN_POP   = 3'd4,
    CMD_POP         = 3'd5,
    CMD_PEEK        = 3'd6,
    CMD_COMMIT_POP  = 3'd7
  } cmd_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              accepted;
    logic [CNT_W-1:0]  fill_level;
    logic [CNT_W-1:0]  free_space;
  } result_t;

endpackage

FILE: src/tbrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module tbrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/transactional_byte_ring_fifo_unit.sv
// Transactional byte ring FIFO: command decode, pointers and result beats.
// Depends on tbrf_pkg and tbrf_ram (the byte store).
// Results: every result beat leaves through the output register; an accepted
// pop or peek first waits in ST_READ for the byte store's registered read.
// Throughput: one command per cycle while in_stall is low; it is raised during
// the store read of a pop or peek and while the hold slot is full.
// Reset: pointers and counts clear, capacity goes to 256; the store is kept.
module transactional_byte_ring_fifo_unit
  import tbrf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [CNT_W-1:0]  cfg_write_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CMD_W-1:0]  command,
  input  logic [CNT_W-1:0]  request_count,
  input  logic [DATA_W-1:0] data_in,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] data_out,
  output logic              accepted,
  output logic [CNT_W-1:0]  fill_level,
  output logic [CNT_W-1:0]  free_space
);

  state_t            state, state_next;
  logic [CNT_W-1:0]  cap;
  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  level, level_next;
  logic [IDX_W-1:0]  cursor, cursor_next;
  logic [CNT_W-1:0]  pending, pending_next;

  result_t           res, out_beat, hold_beat;
  logic              res_valid;
  logic              hold_valid;
  logic              in_accept;
  logic              cmd_ok;
  logic              start_read;
  logic              mem_we;
  logic [DATA_W-1:0] mem_rdata;

  cmd_t              cmd;
  logic [CNT_W:0]    sum_lp;
  logic [CNT_W-1:0]  room;
  logic [CNT_W:0]    head_lvl;
  logic [CNT_W:0]    head_pend;
  logic [CNT_W-1:0]  cursor_inc;
  logic              out_free;

  assign cmd       = cmd_t'(command);
  assign in_stall  = (state != ST_IDLE) || hold_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  assign sum_lp     = {1'b0, level} + {1'b0, pending};
  assign room       = cap - level;
  assign head_lvl   = {2'b00, head} + {1'b0, level};
  assign head_pend  = {2'b00, head} + {1'b0, pending};
  assign cursor_inc = {1'b0, cursor} + CNT_W'(1);

  tbrf_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cursor),
    .wdata (data_in),
    .raddr (cursor),
    .rdata (mem_rdata)
  );

  // Command evaluation and pointer updates
  always_comb begin
    head_next    = head;
    level_next   = level;
    cursor_next  = cursor;
    pending_next = pending;
    cmd_ok       = 1'b0;
    mem_we       = 1'b0;
    start_read   = 1'b0;
    if (in_accept) begin
      case (cmd)
        CMD_CLEAR: begin
          head_next    = '0;
          level_next   = '0;
          cursor_next  = '0;
          pending_next = '0;
          cmd_ok       = 1'b1;
        end
        CMD_BEGIN_PUSH: begin
          if (request_count <= room) begin
            pending_next = '0;
            if (head_lvl >= {1'b0, cap}) begin
              cursor_next = IDX_W'(head_lvl - {1'b0, cap});
            end else begin
              cursor_next = IDX_W'(head_lvl);
            end
            cmd_ok = 1'b1;
          end
        end
        CMD_PUSH: begin
          if (sum_lp < {1'b0, cap}) begin
            mem_we       = 1'b1;
            cursor_next  = (cursor_inc >= cap) ? '0 : IDX_W'(cursor_inc);
            pending_next = pending + CNT_W'(1);
            cmd_ok       = 1'b1;
          end
        end
        CMD_COMMIT_PUSH: begin
          if (sum_lp <= {1'b0, cap}) begin
            level_next   = CNT_W'(sum_lp);
            pending_next = '0;
            cmd_ok       = 1'b1;
          end
        end
        CMD_BEGIN_POP: begin
          if (request_count <= level) begin
            pending_next = '0;
            cursor_next  = head;
            cmd_ok       = 1'b1;
          end
        end
        CMD_POP: begin
          if (pending < level) begin
            cursor_next  = (cursor_inc >= cap) ? '0 : IDX_W'(cursor_inc);
            pending_next = pending + CNT_W'(1);
            start_read   = 1'b1;
            cmd_ok       = 1'b1;
          end
        end
        CMD_PEEK: begin
          if (pending < level) begin
            start_read = 1'b1;
            cmd_ok     = 1'b1;
          end
        end
        CMD_COMMIT_POP: begin
          if (pending <= level) begin
            if (head_pend >= {1'b0, cap}) begin
              head_next = IDX_W'(head_pend - {1'b0, cap});
            end else begin
              head_next = IDX_W'(head_pend);
            end
            level_next   = level - pending;
            pending_next = '0;
            cmd_ok       = 1'b1;
          end
        end
        default: begin
          cmd_ok = 1'b0;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_read) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Result beat
  always_comb begin
    res       = '0;
    res_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        res_valid       = in_accept && !start_read;
        res.accepted    = cmd_ok;
        res.fill_level  = level_next;
        res.free_space  = cap - level_next;
      end
      ST_READ: begin
        res_valid       = 1'b1;
        res.data_out    = mem_rdata;
        res.accepted    = 1'b1;
        res.fill_level  = level;
        res.free_space  = cap - level;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cap     <= CAP_MAX;
      head    <= '0;
      level   <= '0;
      cursor  <= '0;
      pending <= '0;
    end else if (cfg_write_en) begin
      if (cfg_write_data == '0) begin
        cap <= CAP_MIN;
      end else if (cfg_write_data > CAP_MAX) begin
        cap <= CAP_MAX;
      end else begin
        cap <= cfg_write_data;
      end
      state   <= ST_IDLE;
      head    <= '0;
      level   <= '0;
      cursor  <= '0;
      pending <= '0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      level   <= level_next;
      cursor  <= cursor_next;
      pending <= pending_next;
    end
  end

  // Output register plus one hold slot
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else if (out_free) begin
      out_valid  <= hold_valid || res_valid;
      hold_valid <= 1'b0;
    end else if (res_valid) begin
      hold_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_beat <= hold_valid ? hold_beat : res;
    end else if (res_valid) begin
      hold_beat <= res;
    end
  end

  assign data_out   = out_beat.data_out;
  assign accepted   = out_beat.accepted;
  assign fill_level = out_beat.fill_level;
  assign free_space = out_beat.free_space;

  a_hold_behind_out: assert property (@(posedge clk) disable iff (rst)
    hold_valid |-> out_valid)
    else $error("hold slot filled while output register empty");

  a_level_in_cap: assert property (@(posedge clk) disable iff (rst)
    level <= cap)
    else $error("fill level above capacity");

  a_cursor_in_cap: assert property (@(posedge clk) disable iff (rst)
    {1'b0, cursor} < cap)
    else $error("cursor outside ring");

  a_read_follows_accept: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> $past(in_accept))
    else $error("store read without accepted pop or peek");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (rst)
    (hold_valid && !out_free) |=> hold_valid)
    else $error("held result beat lost");

endmodule
